// ===== hdl/gf2_incremental_elimination_defines.svh =====
// assertion macros shared by the elimination chain
// expects clk and rst_n in the scope of each use
`ifndef GF2_INCREMENTAL_ELIMINATION_DEFINES_SVH
`define GF2_INCREMENTAL_ELIMINATION_DEFINES_SVH

// same-cycle implication
`define GIE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GIE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/gie_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the gf2 elimination chain
// no dependencies
package gie_pkg;

    localparam int VARIABLES_DEFAULT = 48;
    localparam int FIELD_W = 48;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_EVAL  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef struct packed {
        logic valid;
        op_t  op;
        logic par;
        logic done;
    } ctrl_t;

endpackage

// ===== hdl/gie_cell.sv =====
`timescale 1ns / 1ps
// one pivot cell: holds the row whose lowest set bit is PIVOT and reduces a passing word
// depends on gie_pkg and gf2_incremental_elimination_defines.svh
`include "gf2_incremental_elimination_defines.svh"

module gie_cell #(
    parameter int VARIABLES = gie_pkg::VARIABLES_DEFAULT,
    parameter int PIVOT = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  gie_pkg::ctrl_t        ctrl_in,
    input  logic [VARIABLES-1:0]  word_in,
    input  logic [VARIABLES-1:0]  rem_in,
    output gie_pkg::ctrl_t        ctrl_out,
    output logic [VARIABLES-1:0]  word_out,
    output logic [VARIABLES-1:0]  rem_out
);

    logic                 present_reg, present_next;
    logic [VARIABLES-1:0] row_reg, row_next;
    logic                 rhs_reg, rhs_next;
    gie_pkg::ctrl_t       ctrl_reg, ctrl_next;
    logic [VARIABLES-1:0] word_reg, word_next;
    logic [VARIABLES-1:0] rem_reg, rem_next;

    always_comb
    begin
        present_next = present_reg;
        row_next     = row_reg;
        rhs_next     = rhs_reg;
        ctrl_next    = ctrl_reg;
        word_next    = word_reg;
        rem_next     = rem_reg;
        if (advance)
        begin
            ctrl_next = ctrl_in;
            word_next = word_in;
            rem_next  = rem_in;
            if (ctrl_in.valid && !ctrl_in.done)
            begin
                unique case (ctrl_in.op)
                    gie_pkg::OP_ADD:
                    begin
                        if (word_in[PIVOT])
                        begin
                            if (present_reg)
                            begin
                                word_next     = word_in ^ row_reg;
                                ctrl_next.par = ctrl_in.par ^ rhs_reg;
                            end
                            else
                            begin
                                row_next       = word_in;
                                rhs_next       = ctrl_in.par;
                                present_next   = 1'b1;
                                ctrl_next.done = 1'b1;
                            end
                        end
                    end
                    gie_pkg::OP_EVAL:
                    begin
                        if (word_in[PIVOT])
                        begin
                            if (present_reg)
                            begin
                                word_next     = word_in ^ row_reg;
                                ctrl_next.par = ctrl_in.par ^ rhs_reg;
                            end
                            else
                            begin
                                rem_next[PIVOT]  = 1'b1;
                                word_next[PIVOT] = 1'b0;
                            end
                        end
                    end
                    gie_pkg::OP_CLEAR:
                    begin
                        present_next = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= 1'b0;
            ctrl_reg    <= '0;
        end
        else
        begin
            present_reg <= present_next;
            ctrl_reg    <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg  <= row_next;
        rhs_reg  <= rhs_next;
        word_reg <= word_next;
        rem_reg  <= rem_next;
    end

    assign ctrl_out = ctrl_reg;
    assign word_out = word_reg;
    assign rem_out  = rem_reg;

    `GIE_ASSERT_IMP(a_pivot_set, present_reg, row_reg[PIVOT], "stored row lost its pivot bit")
    `GIE_ASSERT_NEXT(a_clear_empties, advance && ctrl_in.valid && (ctrl_in.op == gie_pkg::OP_CLEAR), !present_reg, "clear left a row")
    `GIE_ASSERT_NEXT(a_done_passes, advance && ctrl_in.valid && ctrl_in.done, (word_reg == $past(word_in)) && ctrl_reg.done, "finished add was altered")
    `GIE_ASSERT_IMP(a_eval_reduced, ctrl_reg.valid && (ctrl_reg.op == gie_pkg::OP_EVAL), !word_reg[PIVOT], "evaluate left pivot bit set")

endmodule

// ===== hdl/gie_result.sv =====
`timescale 1ns / 1ps
// result stage: forms the result fields from the last cell and holds them for the consumer
// depends on gie_pkg
module gie_result #(
    parameter int VARIABLES = gie_pkg::VARIABLES_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gie_pkg::ctrl_t                ctrl_in,
    input  logic [VARIABLES-1:0]          rem_in,
    output logic                          advance,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic                          consistent,
    output logic                          is_fixed,
    output logic                          parity,
    output logic [gie_pkg::FIELD_W-1:0]   free_remainder
);

    logic                        valid_reg, valid_next;
    logic                        consistent_reg, consistent_next;
    logic                        fixed_reg, fixed_next;
    logic                        parity_reg, parity_next;
    logic [gie_pkg::FIELD_W-1:0] rem_reg, rem_next;
    logic [gie_pkg::FIELD_W-1:0] rem_ext;

    generate
        if (VARIABLES >= gie_pkg::FIELD_W)
        begin : g_trunc
            assign rem_ext = rem_in[gie_pkg::FIELD_W-1:0];
        end
        else
        begin : g_ext
            assign rem_ext = {{(gie_pkg::FIELD_W-VARIABLES){1'b0}}, rem_in};
        end
    endgenerate

    assign advance = !valid_reg || rsp_ready;

    always_comb
    begin
        valid_next      = valid_reg;
        consistent_next = consistent_reg;
        fixed_next      = fixed_reg;
        parity_next     = parity_reg;
        rem_next        = rem_reg;
        if (advance)
        begin
            valid_next      = ctrl_in.valid;
            consistent_next = 1'b0;
            fixed_next      = 1'b0;
            parity_next     = 1'b0;
            rem_next        = '0;
            unique case (ctrl_in.op)
                gie_pkg::OP_ADD:
                begin
                    consistent_next = ctrl_in.done || !ctrl_in.par;
                end
                gie_pkg::OP_EVAL:
                begin
                    fixed_next  = (rem_ext == '0);
                    parity_next = ctrl_in.par;
                    rem_next    = rem_ext;
                end
                gie_pkg::OP_CLEAR:
                begin
                    consistent_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        consistent_reg <= consistent_next;
        fixed_reg      <= fixed_next;
        parity_reg     <= parity_next;
        rem_reg        <= rem_next;
    end

    assign rsp_valid      = valid_reg;
    assign consistent     = consistent_reg;
    assign is_fixed       = fixed_reg;
    assign parity         = parity_reg;
    assign free_remainder = rem_reg;

endmodule

// ===== hdl/gf2_incremental_elimination.sv =====
`timescale 1ns / 1ps
// throughput: one transaction per cycle when not stalled; each pivot cell updates its row
// as a transaction passes, so a later transaction always sees the rows of earlier ones
// the whole chain stalls while a result waits for rsp_ready
// reset empties every pivot row and drops all transactions in flight
module gf2_incremental_elimination #(
    parameter int VARIABLES = gie_pkg::VARIABLES_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic [1:0]                    operation,
    input  logic [gie_pkg::FIELD_W-1:0]   coefficients,
    input  logic                          rhs_bit,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic                          consistent,
    output logic                          is_fixed,
    output logic                          parity,
    output logic [gie_pkg::FIELD_W-1:0]   free_remainder
);

    gie_pkg::ctrl_t       ctrl_chain [VARIABLES+1];
    logic [VARIABLES-1:0] word_chain [VARIABLES+1];
    logic [VARIABLES-1:0] rem_chain  [VARIABLES+1];
    logic                 advance;
    gie_pkg::op_t         op_in;

    generate
        if (VARIABLES > gie_pkg::FIELD_W)
        begin : g_coef_ext
            assign word_chain[0] = {{(VARIABLES-gie_pkg::FIELD_W){1'b0}}, coefficients};
        end
        else
        begin : g_coef_trunc
            assign word_chain[0] = coefficients[VARIABLES-1:0];
        end
    endgenerate

    assign op_in = gie_pkg::op_t'(operation);

    always_comb
    begin
        ctrl_chain[0].valid = req_valid;
        ctrl_chain[0].op    = op_in;
        ctrl_chain[0].par   = (op_in == gie_pkg::OP_ADD) ? rhs_bit : 1'b0;
        ctrl_chain[0].done  = 1'b0;
    end

    assign rem_chain[0] = '0;
    assign req_ready    = advance;

    generate
        for (genvar p = 0; p < VARIABLES; p++)
        begin : g_cell
            gie_cell #(
                .VARIABLES (VARIABLES),
                .PIVOT     (p)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .advance  (advance),
                .ctrl_in  (ctrl_chain[p]),
                .word_in  (word_chain[p]),
                .rem_in   (rem_chain[p]),
                .ctrl_out (ctrl_chain[p+1]),
                .word_out (word_chain[p+1]),
                .rem_out  (rem_chain[p+1])
            );
        end
    endgenerate

    gie_result #(
        .VARIABLES (VARIABLES)
    ) u_result (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl_in        (ctrl_chain[VARIABLES]),
        .rem_in         (rem_chain[VARIABLES]),
        .advance        (advance),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .consistent     (consistent),
        .is_fixed       (is_fixed),
        .parity         (parity),
        .free_remainder (free_remainder)
    );

endmodule
